// File: src/assert_macros.svh
// assertion macros used by the table rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, held off while in reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// clocked check with its own message
`define ASSERT_CLK_MSG(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`else

`define ASSERT_CLK(label, prop)
`define ASSERT_CLK_MSG(label, prop, msg)

`endif

`endif

// File: src/lpkv_pkg.sv
// shared types and constants of the linear probe key/value table
package lpkv_pkg;

  // default sizes
  localparam int SLOT_COUNT_DEF  = 16;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // port field widths
  localparam int OP_W     = 2;
  localparam int HOME_W   = 4;
  localparam int KEY_IN_W = 32;
  localparam int VAL_IN_W = 32;
  localparam int STATUS_W = 3;

  // input beat tdata width, rounded up to whole bytes
  localparam int IN_DATA_W = ((HOME_W + KEY_IN_W + VAL_IN_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_GET    = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_UPDATED   = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_PROBE = 3'b100
  } state_t;

endpackage

// File: src/linear_probe_key_value_table.sv
// linear probe key/value table: open-addressed store with get, add and remove
//
// Each input beat carries an operation (get, add/update, remove), a
// precomputed home slot, a key and a value. The table probes slots from the
// home slot upward, wrapping at SLOT_COUNT (a power of two), one slot per
// clock through the single read port of the slot RAM. On accept the home
// slot is read; each probe step checks the entry just read and reads the
// next one, and the result lands in the output register once the probe
// stops and that register is free. A get or remove that misses, and an add
// on a full table, probe every slot. in_tready is high only while no item
// is in flight; a finished result may wait in the output register while the
// next item is taken. After reset the block sweeps the RAM to clear every
// valid mark, with in_tready low. The home slot is taken modulo SLOT_COUNT
// and the key and value are cut or zero-extended to KEY_WIDTH and VALUE_WIDTH.
`include "assert_macros.svh"

module linear_probe_key_value_table
  import lpkv_pkg::*;
#(
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input beat
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // home_slot[3:0], lookup_key[35:4],
                                           // entry_value[67:36], zero pad
  input  logic [OP_W-1:0]      in_tuser,   // operation[1:0]
  // result beat
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [VAL_IN_W-1:0]  out_tdata,  // value_out[31:0]
  output logic [STATUS_W-1:0]  out_tuser   // status[2:0]
);

  localparam int SLOT_AW = $clog2(SLOT_COUNT);
  localparam int ENTRY_W = 1 + KEY_WIDTH + VALUE_WIDTH;

  // unpack the input beat
  logic [HOME_W-1:0]      in_home;
  logic [KEY_IN_W-1:0]    in_key;
  logic [VAL_IN_W-1:0]    in_val;
  logic [SLOT_AW-1:0]     home_idx;
  logic [KEY_WIDTH-1:0]   key_in_w;
  logic [VALUE_WIDTH-1:0] val_in_w;

  assign in_home = in_tdata[HOME_W-1:0];
  assign in_key  = in_tdata[HOME_W +: KEY_IN_W];
  assign in_val  = in_tdata[HOME_W+KEY_IN_W +: VAL_IN_W];

  // home slot modulo slot count
  generate
    if (SLOT_AW <= HOME_W) begin : g_home_cut
      assign home_idx = in_home[SLOT_AW-1:0];
    end else begin : g_home_ext
      assign home_idx = {{(SLOT_AW-HOME_W){1'b0}}, in_home};
    end
    if (KEY_WIDTH <= KEY_IN_W) begin : g_key_cut
      assign key_in_w = in_key[KEY_WIDTH-1:0];
    end else begin : g_key_ext
      assign key_in_w = {{(KEY_WIDTH-KEY_IN_W){1'b0}}, in_key};
    end
    if (VALUE_WIDTH <= VAL_IN_W) begin : g_val_cut
      assign val_in_w = in_val[VALUE_WIDTH-1:0];
    end else begin : g_val_ext
      assign val_in_w = {{(VALUE_WIDTH-VAL_IN_W){1'b0}}, in_val};
    end
  endgenerate

  // sequencer state
  state_t                 state_r, state_nxt;
  logic [SLOT_AW-1:0]     cnt_r, cnt_nxt;          // slots checked, or clear address
  logic [SLOT_AW-1:0]     chk_slot_r, chk_slot_nxt; // slot whose entry sits in rdata
  logic [SLOT_AW-1:0]     home_r;
  logic [OP_W-1:0]        op_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, status_nxt;
  logic [VALUE_WIDTH-1:0] out_value_r, value_nxt;

  // slot ram port
  logic                   mem_we, mem_re;
  logic [SLOT_AW-1:0]     mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0]     mem_wdata, mem_rdata;

  // entry just read: {valid, key, value}
  logic                   rd_valid;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic                   key_eq, stop, last, out_free, finish, advance, accept;

  assign rd_valid = mem_rdata[ENTRY_W-1];
  assign rd_key   = mem_rdata[VALUE_WIDTH +: KEY_WIDTH];
  assign rd_val   = mem_rdata[VALUE_WIDTH-1:0];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign key_eq   = rd_valid && (rd_key == key_r);
  assign last     = (cnt_r == {SLOT_AW{1'b1}});
  assign out_free = !out_valid_r || out_tready;

  // probe stop rule per operation
  always_comb begin
    case (op_r)
      OP_GET:    stop = key_eq;
      OP_REMOVE: stop = key_eq;
      OP_ADD:    stop = !rd_valid || key_eq;
      default:   stop = 1'b1;  // unused code answers at once
    endcase
  end

  assign finish  = (state_r == S_PROBE) && (stop || last) && out_free;
  assign advance = (state_r == S_PROBE) && !stop && !last;

  // read the home slot on accept, the next slot on each step
  assign mem_re    = accept || advance;
  assign mem_raddr = accept ? home_idx : chk_slot_r + 1'b1;

  // result of the slot under check
  always_comb begin
    status_nxt = ST_NOT_FOUND;
    value_nxt  = '0;
    case (op_r)
      OP_GET, OP_REMOVE: begin
        if (stop) begin
          status_nxt = ST_FOUND;
          value_nxt  = rd_val;
        end
      end
      OP_ADD: begin
        if (!stop) begin
          status_nxt = ST_FULL;
        end else if (rd_valid) begin
          status_nxt = ST_UPDATED;
        end else begin
          status_nxt = ST_INSERTED;
        end
      end
      default: begin
        status_nxt = ST_NOT_FOUND;
      end
    endcase
  end

  // writes: clearing sweep, insert/update, or dropping the valid mark
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = chk_slot_r;
    mem_wdata = {1'b1, key_r, val_r};
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r;
      mem_wdata = '0;
    end else if (finish && stop) begin
      case (op_r)
        OP_ADD: begin
          mem_we = 1'b1;
        end
        OP_REMOVE: begin
          mem_we    = 1'b1;
          mem_wdata = {1'b0, rd_key, rd_val};
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    chk_slot_nxt = chk_slot_r;
    case (state_r)
      S_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt    = S_PROBE;
          cnt_nxt      = '0;
          chk_slot_nxt = home_idx;
        end
      end
      S_PROBE: begin
        if (finish) begin
          state_nxt = S_IDLE;
        end else if (advance) begin
          cnt_nxt      = cnt_r + 1'b1;
          chk_slot_nxt = chk_slot_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item payload and result, no reset needed
  always_ff @(posedge clk) begin
    chk_slot_r <= chk_slot_nxt;
    if (accept) begin
      home_r <= home_idx;
      op_r   <= in_tuser;
      key_r  <= key_in_w;
      val_r  <= val_in_w;
    end
    if (finish) begin
      out_status_r <= status_nxt;
      out_value_r  <= value_nxt;
    end
  end

  lpkv_slot_ram #(
    .DEPTH (SLOT_COUNT),
    .AW    (SLOT_AW),
    .WIDTH (ENTRY_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result beat
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  generate
    if (VALUE_WIDTH >= VAL_IN_W) begin : g_out_cut
      assign out_tdata = out_value_r[VAL_IN_W-1:0];
    end else begin : g_out_ext
      assign out_tdata = {{(VAL_IN_W-VALUE_WIDTH){1'b0}}, out_value_r};
    end
  endgenerate

  // the slot under check always sits cnt_r places past home
  `ASSERT_CLK(a_probe_offset, (state_r == S_PROBE) |-> (chk_slot_r == SLOT_AW'(home_r + cnt_r)))
  // after the last slot the item ends as soon as the output is free
  `ASSERT_CLK(a_probe_bound, (state_r == S_PROBE && last && out_free) |=> (state_r == S_IDLE))
  // a new result only comes out of a probe
  `ASSERT_CLK_MSG(a_result_src, $rose(out_valid_r) |-> $past(state_r == S_PROBE), "stray result")
  // the table is never written while waiting for an item
  `ASSERT_CLK(a_no_idle_write, (state_r == S_IDLE) |-> !mem_we)

endmodule

// File: src/lpkv_slot_ram.sv
// slot store: one write port, one registered read port
module lpkv_slot_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int WIDTH = 65
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: test/tb_linear_probe_key_value_table.sv
// testbench for the linear probe key/value table: directed rows, then random traffic
`timescale 1ns / 1ps

module tb_linear_probe_key_value_table;
  import lpkv_pkg::*;

  // operation code with no meaning: changes nothing, answers not found
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  localparam int RANDOM_ITEMS = 1350;
  // worst case is the longest probe per item plus idling on both sides,
  // so this leaves a wide margin
  localparam int CYCLE_LIMIT = 400000;
  // well past the longest probe, for the quiet period at the end
  localparam int DRAIN_CYCLES = 2 * SLOT_COUNT_DEF + 8;
  localparam int KEY_POOL_SIZE = 24;

  typedef struct {
    status_t          status;
    logic [VAL_IN_W-1:0] value;
  } table_result_t;

  // one directed stimulus row; typed rows carry their answer inline
  typedef struct {
    logic [OP_W-1:0]     op;
    logic [HOME_W-1:0]   home;
    logic [KEY_IN_W-1:0] key;
    logic [VAL_IN_W-1:0] val;
    bit                  typed;
    status_t             exp_status;
    logic [VAL_IN_W-1:0] exp_value;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata;    // home_slot[3:0], lookup_key[35:4],
                                     // entry_value[67:36], zero pad
  logic [OP_W-1:0]      in_tuser;    // operation[1:0]
  logic                 out_tvalid;
  logic                 out_tready;
  logic [VAL_IN_W-1:0]  out_tdata;   // value_out[31:0]
  logic [STATUS_W-1:0]  out_tuser;   // status[2:0]

  // shadow copy of the table contents
  bit                  shadow_valid [SLOT_COUNT_DEF];
  logic [KEY_IN_W-1:0] shadow_key   [SLOT_COUNT_DEF];
  logic [VAL_IN_W-1:0] shadow_value [SLOT_COUNT_DEF];

  table_result_t pending_results[$];
  dir_row_t      dir_rows[$];
  logic [KEY_IN_W-1:0] key_pool [KEY_POOL_SIZE];

  int  fail_count  = 0;
  int  cycle_count = 0;
  int  rx_cycle    = 0;
  bit  sender_calm = 1'b0;

  linear_probe_key_value_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("mismatch %s: got %h, expected %h (cycle %0d)", what, got, exp,
             cycle_count);
    fail_count++;
  endtask

  // applies one operation to the shadow table and returns its answer
  function automatic table_result_t apply_to_table(input logic [OP_W-1:0] op,
                                                   input logic [HOME_W-1:0] home,
                                                   input logic [KEY_IN_W-1:0] key,
                                                   input logic [VAL_IN_W-1:0] val);
    table_result_t res;
    logic [HOME_W-1:0] s;
    bit done;
    res.status = ST_NOT_FOUND;
    res.value  = '0;
    s    = home;
    done = 1'b0;
    case (op)
      OP_GET, OP_REMOVE: begin
        // full scan, invalid slots are stepped over
        for (int n = 0; n < SLOT_COUNT_DEF; n++) begin
          if (!done && shadow_valid[s] && shadow_key[s] == key) begin
            res.status = ST_FOUND;
            res.value  = shadow_value[s];
            if (op == OP_REMOVE) shadow_valid[s] = 1'b0;
            done = 1'b1;
          end
          s = s + 1'b1;
        end
      end
      OP_ADD: begin
        // first free slot or first matching key ends the scan
        res.status = ST_FULL;
        for (int n = 0; n < SLOT_COUNT_DEF; n++) begin
          if (!done) begin
            if (!shadow_valid[s]) begin
              shadow_valid[s] = 1'b1;
              shadow_key[s]   = key;
              shadow_value[s] = val;
              res.status = ST_INSERTED;
              done = 1'b1;
            end else if (shadow_key[s] == key) begin
              shadow_value[s] = val;
              res.status = ST_UPDATED;
              done = 1'b1;
            end
          end
          s = s + 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_row(input logic [OP_W-1:0] op, input logic [HOME_W-1:0] home,
                                  input logic [KEY_IN_W-1:0] key,
                                  input logic [VAL_IN_W-1:0] val, input bit typed,
                                  input status_t exp_status,
                                  input logic [VAL_IN_W-1:0] exp_value);
    dir_row_t r;
    r.op = op; r.home = home; r.key = key; r.val = val;
    r.typed = typed; r.exp_status = exp_status; r.exp_value = exp_value;
    dir_rows.push_back(r);
  endfunction

  // offers one beat, waits for the handshake, then records the expectation
  task automatic send_item(input logic [OP_W-1:0] op, input logic [HOME_W-1:0] home,
                           input logic [KEY_IN_W-1:0] key,
                           input logic [VAL_IN_W-1:0] val, input bit typed,
                           input status_t exp_status,
                           input logic [VAL_IN_W-1:0] exp_value);
    table_result_t res;
    // random idle cycles ahead of the beat
    while (!sender_calm && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - HOME_W - KEY_IN_W - VAL_IN_W){1'b0}}, val, key, home};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // beat taken at this edge
    res = apply_to_table(op, home, key, val);
    if (typed) begin
      res.status = exp_status;
      res.value  = exp_value;
    end
    pending_results.push_back(res);
  endtask

  // result checker: every beat against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", {29'd0, out_tuser}, 32'd0);
      end else begin
        if (out_tuser !== pending_results[0].status)
          report_mismatch("status", {29'd0, out_tuser}, {29'd0, pending_results[0].status});
        if (out_tdata !== pending_results[0].value)
          report_mismatch("value_out", out_tdata, pending_results[0].value);
        void'(pending_results.pop_front());
      end
    end
  end

  // receiver: random stalls, one long hold-off to back the block up,
  // then a long stretch that always accepts
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle >= 1500 && rx_cycle < 1800)
        out_tready <= 1'b0;
      else if (rx_cycle >= 6000 && rx_cycle < 10000)
        out_tready <= 1'b1;
      else
        out_tready <= ($urandom_range(99) >= 10);
    end
  end

  // stimulus and end of run
  initial begin
    logic [OP_W-1:0]     op;
    logic [HOME_W-1:0]   home;
    logic [KEY_IN_W-1:0] key;
    logic [VAL_IN_W-1:0] val;
    int r;
    int mode;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_GET;
    for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
    end
    // key pool: a few more keys than slots so adds can fill the table
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    // empty table, extremes, reserved code
    add_row(OP_GET,      4'd0,  32'h0000_0000, 32'h0000_0000, 1, ST_NOT_FOUND, 32'h0);
    add_row(OP_REMOVE,   4'd15, 32'hFFFF_FFFF, 32'h0000_0000, 1, ST_NOT_FOUND, 32'h0);
    add_row(OP_RESERVED, 4'd7,  32'hDEAD_BEEF, 32'hFFFF_FFFF, 1, ST_NOT_FOUND, 32'h0);
    add_row(OP_ADD,      4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_INSERTED,  32'h0);
    add_row(OP_GET,      4'd15, 32'hFFFF_FFFF, 32'h0000_0000, 1, ST_FOUND, 32'hFFFF_FFFF);
    add_row(OP_ADD,      4'd15, 32'hFFFF_FFFF, 32'h0000_0000, 1, ST_UPDATED,   32'h0);
    // scan wraps from slot 15 to slot 0
    add_row(OP_GET,      4'd0,  32'hFFFF_FFFF, 32'h1234_5678, 0, ST_FOUND, 32'h0);
    add_row(OP_ADD,      4'd15, 32'h0000_0000, 32'hA5A5_A5A5, 0, ST_FOUND, 32'h0);
    add_row(OP_GET,      4'd15, 32'h0000_0000, 32'h0000_0000, 0, ST_FOUND, 32'h0);
    add_row(OP_RESERVED, 4'd0,  32'h0000_0000, 32'h0000_0000, 1, ST_NOT_FOUND, 32'h0);
    // add stops at the first free slot even with the key further on
    add_row(OP_ADD,      4'd3,  32'h0000_1111, 32'h0000_0001, 0, ST_FOUND, 32'h0);
    add_row(OP_ADD,      4'd3,  32'h0000_2222, 32'h0000_0002, 0, ST_FOUND, 32'h0);
    add_row(OP_REMOVE,   4'd3,  32'h0000_1111, 32'h0000_0000, 0, ST_FOUND, 32'h0);
    add_row(OP_ADD,      4'd3,  32'h0000_2222, 32'h0000_0003, 0, ST_FOUND, 32'h0);
    add_row(OP_GET,      4'd3,  32'h0000_2222, 32'h0000_0000, 0, ST_FOUND, 32'h0);
    // remove steps over the freed slot to reach the older copy
    add_row(OP_REMOVE,   4'd3,  32'h0000_2222, 32'h0000_0000, 0, ST_FOUND, 32'h0);
    add_row(OP_REMOVE,   4'd3,  32'h0000_2222, 32'h0000_0000, 0, ST_FOUND, 32'h0);
    add_row(OP_REMOVE,   4'd3,  32'h0000_2222, 32'h0000_0000, 0, ST_FOUND, 32'h0);
    add_row(OP_GET,      4'd9,  32'hFFFF_FFFF, 32'h0000_0000, 0, ST_FOUND, 32'h0);
    add_row(OP_REMOVE,   4'd0,  32'h0000_0000, 32'h0000_0000, 0, ST_FOUND, 32'h0);
    add_row(OP_ADD,      4'd8,  32'h8000_0000, 32'h5555_5555, 0, ST_FOUND, 32'h0);
    add_row(OP_GET,      4'd8,  32'h8000_0000, 32'h0000_0000, 0, ST_FOUND, 32'h0);
    add_row(OP_ADD,      4'd7,  32'h7FFF_FFFF, 32'hAAAA_AAAA, 0, ST_FOUND, 32'h0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // block clears its valid marks first, in_tready stays low meanwhile
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].home, dir_rows[i].key, dir_rows[i].val,
                dir_rows[i].typed, dir_rows[i].exp_status, dir_rows[i].exp_value);

    // random traffic in phases: filling, draining, mixed
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      mode = (n / 150) % 3;
      sender_calm = (n >= 450 && n < 700);
      r = $urandom_range(99);
      case (mode)
        0:       op = (r < 70) ? OP_ADD : (r < 85) ? OP_GET : (r < 95) ? OP_REMOVE : OP_RESERVED;
        1:       op = (r < 50) ? OP_REMOVE : (r < 80) ? OP_GET : (r < 95) ? OP_ADD : OP_RESERVED;
        default: op = (r < 35) ? OP_GET : (r < 70) ? OP_ADD : (r < 95) ? OP_REMOVE : OP_RESERVED;
      endcase
      key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(KEY_POOL_SIZE - 1)]
                                      : $urandom;
      // mostly a hash of the key, sometimes any slot
      home = ($urandom_range(99) < 60) ? (key[3:0] ^ key[7:4])
                                       : HOME_W'($urandom_range(SLOT_COUNT_DEF - 1));
      r = $urandom_range(19);
      val = (r == 0) ? 32'h0000_0000 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
      send_item(op, home, key, val, 0, ST_FOUND, 32'h0);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/lpkv_pkg.sv
src/lpkv_slot_ram.sv
src/linear_probe_key_value_table.sv
test/tb_linear_probe_key_value_table.sv
